[rtl/core/allm_pkg.sv]
// Shared types and constants of the array linked list manager.
package allm_pkg;

    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 8;
    localparam int PAYLOAD_W = 32;
    localparam int KEY_W     = 32;
    localparam int KIND_W    = 16;
    localparam int LINK_W    = 9;
    localparam int CNT_W     = 9;
    localparam int DATA_W    = PAYLOAD_W + KEY_W + KIND_W;

    localparam logic signed [LINK_W-1:0] LINK_NONE_OUT = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NOT_USED  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AP_RD,
        S_AP_WR,
        S_SL_RD,
        S_SL_CHK,
        S_RM_FIN,
        S_FD_RD,
        S_FD_CMP,
        S_DONE
    } t_state;

endpackage

[rtl/core/allm_cmd_if.sv]
// Command channel carrying one list operation per item.
interface allm_cmd_if import allm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [SLOT_W-1:0]    slot;
    logic [PAYLOAD_W-1:0] payload;
    logic [KEY_W-1:0]     key;
    logic [KIND_W-1:0]    kind;

    modport source (output valid, command, slot, payload, key, kind, input ready);
    modport sink (input valid, command, slot, payload, key, kind, output ready);
endinterface

[rtl/core/allm_res_if.sv]
// Result channel carrying one outcome per command item.
interface allm_res_if import allm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [SLOT_W-1:0]         result_slot;
    logic [PAYLOAD_W-1:0]      result_payload;
    logic [KIND_W-1:0]         result_kind;
    logic signed [LINK_W-1:0]  next_link;
    logic signed [LINK_W-1:0]  prev_link;
    logic signed [LINK_W-1:0]  head_slot;
    logic signed [LINK_W-1:0]  tail_slot;
    logic [CNT_W-1:0]          entry_count;

    modport source (
        output valid, status, result_slot, result_payload, result_kind,
               next_link, prev_link, head_slot, tail_slot, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, result_slot, result_payload, result_kind,
               next_link, prev_link, head_slot, tail_slot, entry_count,
        output ready
    );
endinterface

[rtl/core/array_linked_list_manager_top.sv]
// Top level of the array linked list manager with its command sequencer.
//
//   Port     Dir  Handshake      Content
//   i_cmd    in   valid/ready    command, slot, payload, key, kind
//   o_res    out  valid/ready    status, slot, payload, kind, links, head, tail, count
//
// Append writes the new entry into the first free slot, links it after the tail,
// or reports full at once; read and remove read the slot and check it, and remove
// then puts the slot on the free chain; find reads and compares one entry at a time
// from the head through the single read port of the slot memories and the one key
// comparator. Reset needs no clearing pass: a counter of never used slots stands in
// for the initial free chain. A new item is taken only while the sequencer is idle;
// a stalled result holds in the output register while the next item is worked.
module array_linked_list_manager_top import allm_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    allm_cmd_if.sink   i_cmd,
    allm_res_if.source o_res
);

    localparam int SW   = $clog2(CAPACITY);
    localparam int CMPW = (SW + 1 > SLOT_W) ? SW + 1 : SLOT_W;
    localparam logic [SW:0] LINK_NONE = {1'b1, {SW{1'b0}}};
    localparam logic [SW:0] CAP_VAL   = (SW + 1)'(CAPACITY);

    function automatic logic signed [LINK_W-1:0] f_enc(input logic [SW:0] link);
        return link[SW] ? LINK_NONE_OUT : LINK_W'(link[SW-1:0]);
    endfunction

    t_state                   r_state, n_state;
    t_cmd                     r_cmd, n_cmd;
    logic [SW:0]              r_head, n_head;
    logic [SW:0]              r_tail, n_tail;
    logic [SW:0]              r_free, n_free;
    logic [SW:0]              r_fresh, n_fresh;
    logic [SW:0]              r_count, n_count;
    logic [SW:0]              r_cur, n_cur;
    logic [SLOT_W-1:0]        r_slot, n_slot;
    logic [PAYLOAD_W-1:0]     r_pay, n_pay;
    logic [KEY_W-1:0]         r_key, n_key;
    logic [KIND_W-1:0]        r_kind, n_kind;
    t_status                  r_status, n_status;
    logic [SLOT_W-1:0]        r_rslot, n_rslot;
    logic [PAYLOAD_W-1:0]     r_rpay, n_rpay;
    logic [KIND_W-1:0]        r_rkind, n_rkind;
    logic signed [LINK_W-1:0] r_rnext, n_rnext;
    logic signed [LINK_W-1:0] r_rprev, n_rprev;
    logic                     r_ovalid, n_ovalid;
    logic                     w_load_out;
    t_status                  r_o_status;
    logic [SLOT_W-1:0]        r_o_slot;
    logic [PAYLOAD_W-1:0]     r_o_pay;
    logic [KIND_W-1:0]        r_o_kind;
    logic signed [LINK_W-1:0] r_o_next, r_o_prev, r_o_head, r_o_tail;
    logic [CNT_W-1:0]         r_o_count;

    logic [SW-1:0]            w_slot_idx;
    logic [SW-1:0]            w_raddr;
    logic                     w_data_we;
    logic [DATA_W-1:0]        w_data_rdata;
    logic                     w_next_we, w_prev_we, w_used_we;
    logic [SW-1:0]            w_next_waddr, w_prev_waddr, w_used_waddr;
    logic [SW:0]              w_next_wdata, w_prev_wdata;
    logic                     w_used_wdata;
    logic [SW:0]              w_next_rdata, w_prev_rdata;
    logic                     w_used_rdata;
    logic                     w_accept;

    assign w_slot_idx = SW'(r_slot);
    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    always_comb begin
        case (r_state)
            S_AP_RD: w_raddr = r_free[SW-1:0];
            S_FD_RD: w_raddr = r_cur[SW-1:0];
            default: w_raddr = w_slot_idx;
        endcase
    end

    allm_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_data_we),
        .i_waddr (r_free[SW-1:0]),
        .i_wdata ({r_pay, r_key, r_kind}),
        .i_raddr (w_raddr),
        .o_rdata (w_data_rdata)
    );

    allm_ram #(.WIDTH(SW + 1), .DEPTH(CAPACITY)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_waddr),
        .i_wdata (w_next_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_next_rdata)
    );

    allm_ram #(.WIDTH(SW + 1), .DEPTH(CAPACITY)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prev_we),
        .i_waddr (w_prev_waddr),
        .i_wdata (w_prev_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_prev_rdata)
    );

    allm_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_used_we),
        .i_waddr (w_used_waddr),
        .i_wdata (w_used_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_used_rdata)
    );

    always_comb begin
        logic [SW:0] v_nx;
        logic [SW:0] v_pv;
        logic [SW:0] v_sidx;
        logic        v_valid;

        n_state  = r_state;
        n_cmd    = r_cmd;
        n_head   = r_head;
        n_tail   = r_tail;
        n_free   = r_free;
        n_fresh  = r_fresh;
        n_count  = r_count;
        n_cur    = r_cur;
        n_slot   = r_slot;
        n_pay    = r_pay;
        n_key    = r_key;
        n_kind   = r_kind;
        n_status = r_status;
        n_rslot  = r_rslot;
        n_rpay   = r_rpay;
        n_rkind  = r_rkind;
        n_rnext  = r_rnext;
        n_rprev  = r_rprev;
        n_ovalid = r_ovalid && !o_res.ready;
        w_load_out   = 1'b0;
        w_data_we    = 1'b0;
        w_next_we    = 1'b0;
        w_next_waddr = r_free[SW-1:0];
        w_next_wdata = LINK_NONE;
        w_prev_we    = 1'b0;
        w_prev_waddr = r_free[SW-1:0];
        w_prev_wdata = LINK_NONE;
        w_used_we    = 1'b0;
        w_used_waddr = r_free[SW-1:0];
        w_used_wdata = 1'b1;

        v_nx    = w_next_rdata;
        v_pv    = w_prev_rdata;
        v_sidx  = {1'b0, w_slot_idx};
        v_valid = (CMPW'(r_slot) < CMPW'(r_fresh)) && w_used_rdata;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = t_cmd'(i_cmd.command);
                    n_slot   = i_cmd.slot;
                    n_pay    = i_cmd.payload;
                    n_key    = i_cmd.key;
                    n_kind   = i_cmd.kind;
                    n_cur    = r_head;
                    n_status = ST_OK;
                    n_rslot  = '0;
                    n_rpay   = '0;
                    n_rkind  = '0;
                    n_rnext  = LINK_NONE_OUT;
                    n_rprev  = LINK_NONE_OUT;
                    case (t_cmd'(i_cmd.command))
                        CMD_APPEND: n_state = S_AP_RD;
                        CMD_FIND:   n_state = S_FD_RD;
                        default:    n_state = S_SL_RD;
                    endcase
                end
            end
            S_AP_RD: begin
                if (r_free[SW]) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    w_data_we    = 1'b1;
                    w_used_we    = 1'b1;
                    w_prev_we    = 1'b1;
                    w_prev_wdata = r_head[SW] ? LINK_NONE : r_tail;
                    if (!r_head[SW]) begin
                        w_next_we    = 1'b1;
                        w_next_waddr = r_tail[SW-1:0];
                        w_next_wdata = r_free;
                    end
                    n_state = S_AP_WR;
                end
            end
            S_AP_WR: begin
                w_next_we = 1'b1;
                if (r_free == r_fresh) begin
                    n_fresh = r_fresh + 1'b1;
                    n_free  = (r_fresh + 1'b1 == CAP_VAL) ? LINK_NONE : r_fresh + 1'b1;
                end else begin
                    n_free = v_nx;
                end
                if (r_head[SW]) begin
                    n_head = r_free;
                end
                n_tail  = r_free;
                n_count = r_count + 1'b1;
                n_rslot = SLOT_W'(r_free[SW-1:0]);
                n_state = S_DONE;
            end
            S_SL_RD: begin
                n_state = S_SL_CHK;
            end
            S_SL_CHK: begin
                n_rslot = r_slot;
                n_state = S_DONE;
                if (!v_valid) begin
                    n_status = ST_NOT_USED;
                end else if (r_cmd == CMD_READ) begin
                    n_rpay  = w_data_rdata[DATA_W-1 -: PAYLOAD_W];
                    n_rkind = w_data_rdata[KIND_W-1:0];
                    n_rnext = f_enc(v_nx);
                    n_rprev = f_enc(v_pv);
                end else begin
                    w_used_we    = 1'b1;
                    w_used_waddr = w_slot_idx;
                    w_used_wdata = 1'b0;
                    n_count      = r_count - 1'b1;
                    if (v_sidx == r_head) begin
                        n_head = v_nx;
                        if (v_nx[SW]) begin
                            n_tail = LINK_NONE;
                        end else begin
                            w_prev_we    = 1'b1;
                            w_prev_waddr = v_nx[SW-1:0];
                            w_prev_wdata = LINK_NONE;
                        end
                    end else if (v_nx[SW]) begin
                        w_next_we    = 1'b1;
                        w_next_waddr = v_pv[SW-1:0];
                        w_next_wdata = LINK_NONE;
                        n_tail       = v_pv;
                    end else begin
                        w_next_we    = 1'b1;
                        w_next_waddr = v_pv[SW-1:0];
                        w_next_wdata = v_nx;
                        w_prev_we    = 1'b1;
                        w_prev_waddr = v_nx[SW-1:0];
                        w_prev_wdata = v_pv;
                    end
                    n_state = S_RM_FIN;
                end
            end
            S_RM_FIN: begin
                w_next_we    = 1'b1;
                w_next_waddr = w_slot_idx;
                w_next_wdata = r_free;
                n_free       = v_sidx;
                n_state      = S_DONE;
            end
            S_FD_RD: begin
                if (r_cur[SW]) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_FD_CMP;
                end
            end
            S_FD_CMP: begin
                if (w_data_rdata[KIND_W +: KEY_W] == r_key) begin
                    n_rslot = SLOT_W'(r_cur[SW-1:0]);
                    n_rpay  = w_data_rdata[DATA_W-1 -: PAYLOAD_W];
                    n_rkind = w_data_rdata[KIND_W-1:0];
                    n_rnext = f_enc(v_nx);
                    n_rprev = f_enc(v_pv);
                    n_state = S_DONE;
                end else begin
                    n_cur   = v_nx;
                    n_state = S_FD_RD;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_res.ready) begin
                    w_load_out = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= LINK_NONE;
            r_tail   <= LINK_NONE;
            r_free   <= '0;
            r_fresh  <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_free   <= n_free;
            r_fresh  <= n_fresh;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_cur    <= n_cur;
        r_slot   <= n_slot;
        r_pay    <= n_pay;
        r_key    <= n_key;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_rslot  <= n_rslot;
        r_rpay   <= n_rpay;
        r_rkind  <= n_rkind;
        r_rnext  <= n_rnext;
        r_rprev  <= n_rprev;
        if (w_load_out) begin
            r_o_status <= r_status;
            r_o_slot   <= r_rslot;
            r_o_pay    <= r_rpay;
            r_o_kind   <= r_rkind;
            r_o_next   <= r_rnext;
            r_o_prev   <= r_rprev;
            r_o_head   <= f_enc(r_head);
            r_o_tail   <= f_enc(r_tail);
            r_o_count  <= CNT_W'(r_count);
        end
    end

    assign o_res.valid          = r_ovalid;
    assign o_res.status         = r_o_status;
    assign o_res.result_slot    = r_o_slot;
    assign o_res.result_payload = r_o_pay;
    assign o_res.result_kind    = r_o_kind;
    assign o_res.next_link      = r_o_next;
    assign o_res.prev_link      = r_o_prev;
    assign o_res.head_slot      = r_o_head;
    assign o_res.tail_slot      = r_o_tail;
    assign o_res.entry_count    = r_o_count;

    a_count_le_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_fresh)
        else $error("List holds more entries than slots ever allocated.");

    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head[SW] == (r_count == '0)) && (r_tail[SW] == r_head[SW]))
        else $error("Head, tail and count disagree on an empty list.");

    a_free_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free[SW] |-> (r_fresh == CAP_VAL))
        else $error("Free list is empty while unused fresh slots remain.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("Sequencer stayed idle after taking an item.");

endmodule

[rtl/core/allm_ram.sv]
// Generic single write port RAM with one registered read port.
module allm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the array linked list manager: predicts each command item's result.
module tb_top;
    import allm_pkg::*;

    localparam int LIST_CAP    = 256;
    localparam int CYCLE_LIMIT = 2000000;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    typedef struct {
        t_status                  status;
        logic [SLOT_W-1:0]        slot;
        logic [PAYLOAD_W-1:0]     payload;
        logic [KIND_W-1:0]        kind;
        logic signed [LINK_W-1:0] nxt;
        logic signed [LINK_W-1:0] prv;
        logic signed [LINK_W-1:0] head;
        logic signed [LINK_W-1:0] tail;
        logic [CNT_W-1:0]         count;
    } t_list_result;

    logic clk;
    logic rst_n = 1'b0;

    allm_cmd_if cmd_ch ();
    allm_res_if res_ch ();

    array_linked_list_manager_top #(.CAPACITY(LIST_CAP)) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // Shadow copy of the slot pool, free chain and list ends.
    int                   ll_next    [LIST_CAP];
    int                   ll_prev    [LIST_CAP];
    logic [PAYLOAD_W-1:0] ll_payload [LIST_CAP];
    logic [KEY_W-1:0]     ll_key     [LIST_CAP];
    logic [KIND_W-1:0]    ll_kind    [LIST_CAP];
    bit                   ll_used    [LIST_CAP];
    int                   ll_head;
    int                   ll_tail;
    int                   ll_free;
    int                   ll_count;

    t_list_result pending_results [$];
    int           err_count  = 0;
    int           cycle_cnt  = 0;
    int           burst_left = 0;
    bit           gaps_on    = 1'b0;
    int           hold_left  = 0;
    int           rx_phase   = 0;
    t_rx_mode     rx_mode    = RX_ALWAYS;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void reset_list_model();
        for (int i = 0; i < LIST_CAP; i++) begin
            ll_next[i]    = (i + 1 < LIST_CAP) ? i + 1 : -1;
            ll_prev[i]    = 0;
            ll_payload[i] = '0;
            ll_key[i]     = '0;
            ll_kind[i]    = '0;
            ll_used[i]    = 1'b0;
        end
        ll_head  = -1;
        ll_tail  = -1;
        ll_free  = 0;
        ll_count = 0;
    endfunction

    function automatic t_list_result apply_list_op(t_cmd op, logic [SLOT_W-1:0] s,
                                                   logic [PAYLOAD_W-1:0] pay,
                                                   logic [KEY_W-1:0] key,
                                                   logic [KIND_W-1:0] knd);
        t_list_result r;
        int n;
        int nx;
        int pv;
        int cur;
        int steps;
        r.status  = ST_OK;
        r.slot    = '0;
        r.payload = '0;
        r.kind    = '0;
        r.nxt     = LINK_NONE_OUT;
        r.prv     = LINK_NONE_OUT;
        case (op)
            CMD_APPEND: begin
                if (ll_free == -1) begin
                    r.status = ST_FULL;
                end else begin
                    n = ll_free;
                    ll_free = ll_next[n];
                    ll_payload[n] = pay;
                    ll_key[n] = key;
                    ll_kind[n] = knd;
                    ll_used[n] = 1'b1;
                    ll_next[n] = -1;
                    if (ll_head == -1) begin
                        ll_prev[n] = -1;
                        ll_head = n;
                    end else begin
                        ll_next[ll_tail] = n;
                        ll_prev[n] = ll_tail;
                    end
                    ll_tail = n;
                    ll_count++;
                    r.slot = SLOT_W'(n);
                end
            end
            CMD_REMOVE: begin
                r.slot = s;
                if (!ll_used[s]) begin
                    r.status = ST_NOT_USED;
                end else begin
                    nx = ll_next[s];
                    pv = ll_prev[s];
                    if (int'(s) == ll_head) begin
                        ll_head = nx;
                        if (nx == -1) ll_tail = -1;
                        else ll_prev[nx] = -1;
                    end else if (nx == -1) begin
                        ll_next[pv] = -1;
                        ll_tail = pv;
                    end else begin
                        ll_next[pv] = nx;
                        ll_prev[nx] = pv;
                    end
                    ll_used[s] = 1'b0;
                    ll_next[s] = ll_free;
                    ll_free = int'(s);
                    ll_count--;
                end
            end
            CMD_FIND: begin
                cur = ll_head;
                steps = 0;
                r.status = ST_NOT_FOUND;
                while (cur != -1 && steps < LIST_CAP) begin
                    if (ll_key[cur] == key) begin
                        r.status  = ST_OK;
                        r.slot    = SLOT_W'(cur);
                        r.payload = ll_payload[cur];
                        r.kind    = ll_kind[cur];
                        r.nxt     = LINK_W'(ll_next[cur]);
                        r.prv     = LINK_W'(ll_prev[cur]);
                        break;
                    end
                    cur = ll_next[cur];
                    steps++;
                end
            end
            default: begin
                r.slot = s;
                if (!ll_used[s]) begin
                    r.status = ST_NOT_USED;
                end else begin
                    r.payload = ll_payload[s];
                    r.kind    = ll_kind[s];
                    r.nxt     = LINK_W'(ll_next[s]);
                    r.prv     = LINK_W'(ll_prev[s]);
                end
            end
        endcase
        r.head  = LINK_W'(ll_head);
        r.tail  = LINK_W'(ll_tail);
        r.count = CNT_W'(ll_count);
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_live_slot();
        int cur;
        int k;
        cur = ll_head;
        k = $urandom_range(0, ll_count - 1);
        repeat (k) cur = ll_next[cur];
        return SLOT_W'(cur);
    endfunction

    task automatic send_item(input t_cmd op, input logic [SLOT_W-1:0] s,
                             input logic [PAYLOAD_W-1:0] pay, input logic [KEY_W-1:0] key,
                             input logic [KIND_W-1:0] knd);
        t_list_result want;
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= op;
        cmd_ch.slot    <= s;
        cmd_ch.payload <= pay;
        cmd_ch.key     <= key;
        cmd_ch.kind    <= knd;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        want = apply_list_op(op, s, pay, key, knd);
        pending_results.push_back(want);
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                cmd_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    task automatic wait_all_results();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic random_item(input int high_water);
        int r;
        int w_app;
        t_cmd op;
        logic [SLOT_W-1:0] slot_v;
        logic [KEY_W-1:0] key_v;
        r = $urandom_range(0, 99);
        w_app = (ll_count >= high_water) ? 15 : (ll_count < high_water / 4) ? 60 : 35;
        if (r < w_app) op = CMD_APPEND;
        else if (r < w_app + (100 - w_app) * 4 / 10) op = CMD_REMOVE;
        else if (r < w_app + (100 - w_app) * 7 / 10) op = CMD_FIND;
        else op = CMD_READ;
        slot_v = SLOT_W'($urandom);
        key_v = $urandom;
        case (op)
            CMD_APPEND: begin
                if ($urandom_range(0, 3) == 0) key_v = 32'hC0DE_0000 | $urandom_range(0, 7);
            end
            CMD_FIND: begin
                if (ll_count > 0 && $urandom_range(0, 3) != 0) key_v = ll_key[pick_live_slot()];
                else if ($urandom_range(0, 1) == 0) key_v = 32'hC0DE_0000 | $urandom_range(0, 7);
            end
            default: begin
                if (ll_count > 0 && $urandom_range(0, 9) != 0) slot_v = pick_live_slot();
            end
        endcase
        send_item(op, slot_v, $urandom, key_v, KIND_W'($urandom));
    endtask

    task automatic test_directed_cases();
        gaps_on = 1'b0;
        rx_mode <= RX_ALWAYS;
        send_item(CMD_READ, 8'd0, '0, '0, '0);
        send_item(CMD_REMOVE, 8'd255, '0, '0, '0);
        send_item(CMD_FIND, 8'd0, '0, 32'h0, '0);
        send_item(CMD_APPEND, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_APPEND, 8'd255, 32'h0, 32'h0, 16'h0);
        send_item(CMD_APPEND, 8'd0, 32'h1234_5678, 32'hFFFF_FFFF, 16'h4142);
        send_item(CMD_APPEND, 8'd0, 32'hA5A5_5A5A, 32'h0000_5A5A, 16'h5A5A);
        send_item(CMD_FIND, 8'd0, '0, 32'hFFFF_FFFF, '0);
        send_item(CMD_FIND, 8'd0, '0, 32'h0, '0);
        send_item(CMD_READ, 8'd3, '0, '0, '0);
        send_item(CMD_READ, 8'd255, '0, '0, '0);
        send_item(CMD_REMOVE, 8'd0, '0, '0, '0);
        send_item(CMD_READ, 8'd1, '0, '0, '0);
        send_item(CMD_FIND, 8'd0, '0, 32'hFFFF_FFFF, '0);
        send_item(CMD_REMOVE, 8'd3, '0, '0, '0);
        send_item(CMD_REMOVE, 8'd3, '0, '0, '0);
        send_item(CMD_APPEND, 8'd0, 32'h0000_0077, 32'h0000_0077, 16'h0077);
        send_item(CMD_REMOVE, 8'd2, '0, '0, '0);
        send_item(CMD_READ, 8'd1, '0, '0, '0);
        send_item(CMD_READ, 8'd3, '0, '0, '0);
        send_item(CMD_REMOVE, 8'd1, '0, '0, '0);
        send_item(CMD_REMOVE, 8'd3, '0, '0, '0);
        send_item(CMD_APPEND, 8'd0, 32'h8000_0001, 32'h7FFF_FFFE, 16'h8001);
        wait_all_results();
    endtask

    task automatic test_full_pool();
        gaps_on = 1'b1;
        rx_mode <= RX_RANDOM;
        while (ll_count > 0) send_item(CMD_REMOVE, SLOT_W'(ll_head), '0, '0, '0);
        while (ll_count < LIST_CAP)
            send_item(CMD_APPEND, 8'd0, $urandom, $urandom, KIND_W'($urandom));
        send_item(CMD_APPEND, 8'd0, $urandom, $urandom, KIND_W'($urandom));
        send_item(CMD_FIND, 8'd0, '0, ll_key[ll_tail], '0);
        send_item(CMD_FIND, 8'd0, '0, $urandom, '0);
        send_item(CMD_READ, 8'd0, '0, '0, '0);
        send_item(CMD_READ, 8'd255, '0, '0, '0);
        send_item(CMD_REMOVE, SLOT_W'(ll_head), '0, '0, '0);
        send_item(CMD_APPEND, 8'd0, $urandom, $urandom, KIND_W'($urandom));
        send_item(CMD_REMOVE, SLOT_W'(ll_tail), '0, '0, '0);
        send_item(CMD_REMOVE, SLOT_W'(ll_next[ll_head]), '0, '0, '0);
        while (ll_count > 0) send_item(CMD_REMOVE, pick_live_slot(), '0, '0, '0);
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 250; i++) begin
            if (i % 50 == 0) begin
                wait_all_results();
                if (i == 0) begin
                    gaps_on = 1'b0;
                    rx_mode <= RX_ALWAYS;
                end else begin
                    gaps_on = ($urandom_range(0, 3) != 0);
                    rx_mode <= t_rx_mode'($urandom_range(0, 2));
                end
            end
            random_item(24);
        end
        wait_all_results();
    endtask

    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        rx_mode <= RX_ALWAYS;
        hold_left <= 400;
        for (int i = 0; i < 30; i++) random_item(24);
        wait_all_results();
    endtask

    task automatic test_deep_list();
        gaps_on = 1'b1;
        rx_mode <= RX_PATTERN;
        for (int i = 0; i < 100; i++) random_item(250);
        wait_all_results();
    endtask

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            rx_phase++;
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: res_ch.ready <= 1'b1;
                    RX_RANDOM: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    default:   res_ch.ready <= ((rx_phase % 7) < 4);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        t_list_result want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: status=%0d slot=%0d", res_ch.status,
                             res_ch.result_slot);
            end else begin
                want = pending_results.pop_front();
                if (res_ch.status !== want.status || res_ch.result_slot !== want.slot ||
                    res_ch.result_payload !== want.payload ||
                    res_ch.result_kind !== want.kind || res_ch.next_link !== want.nxt ||
                    res_ch.prev_link !== want.prv || res_ch.head_slot !== want.head ||
                    res_ch.tail_slot !== want.tail || res_ch.entry_count !== want.count) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("exp st=%0d slot=%0d pay=%h kind=%h nx=%0d pv=%0d hd=%0d tl=%0d n=%0d",
                                 want.status, want.slot, want.payload, want.kind, want.nxt,
                                 want.prv, want.head, want.tail, want.count);
                        $display("got st=%0d slot=%0d pay=%h kind=%h nx=%0d pv=%0d hd=%0d tl=%0d n=%0d",
                                 res_ch.status, res_ch.result_slot, res_ch.result_payload,
                                 res_ch.result_kind, res_ch.next_link, res_ch.prev_link,
                                 res_ch.head_slot, res_ch.tail_slot, res_ch.entry_count);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("array_linked_list_manager_top: mismatch");
            $finish;
        end
    end

    initial begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = CMD_APPEND;
        cmd_ch.slot    = '0;
        cmd_ch.payload = '0;
        cmd_ch.key     = '0;
        cmd_ch.kind    = '0;
        reset_list_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_full_pool();
        test_random_traffic();
        test_output_backpressure();
        test_deep_list();
        repeat (40) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("array_linked_list_manager_top: match");
        else
            $display("array_linked_list_manager_top: mismatch");
        $finish;
    end

endmodule
